/* design/tcvu_pkg.sv */
// Shared types and constants for the traffic cell vehicle update block.
// Used by tcvu_regs, tcvu_ctrl, tcvu_dp and the top level; depends on nothing.
`default_nettype none

package tcvu_pkg;

    // Field widths of the item and result words
    localparam int CELL_W    = 10;
    localparam int SPEED_W   = 5;
    localparam int DRAW_W    = 16;
    localparam int LEN_CFG_W = 11;
    localparam int THR_W     = 17;

    // Register port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Default map depth and shortest usable ring
    localparam int ROAD_CELLS_DEF = 1024;
    localparam int MIN_ROAD       = 2;

    // Register reset values
    localparam logic [LEN_CFG_W-1:0] ROAD_LENGTH_RST    = 11'd300;
    localparam logic [SPEED_W-1:0]   MAX_SPEED_RST      = 5'd5;
    localparam logic [THR_W-1:0]     SLOW_THRESHOLD_RST = 17'd13107;
    localparam logic [LEN_CFG_W-1:0] MAP_LENGTH_RST     = 11'd300;

    // Item function codes
    localparam logic FUNC_MAP_WRITE = 1'b0;
    localparam logic FUNC_UPDATE    = 1'b1;

    typedef logic [CELL_W-1:0]  cell_t;
    typedef logic [SPEED_W-1:0] speed_t;

    typedef enum logic [1:0] {
        REG_ROAD_LENGTH    = 2'd0,
        REG_MAX_SPEED      = 2'd1,
        REG_SLOW_THRESHOLD = 2'd2,
        REG_MAP_LENGTH     = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [LEN_CFG_W-1:0] road_length;
        logic [SPEED_W-1:0]   max_speed;
        logic [THR_W-1:0]     slow_threshold;
        logic [LEN_CFG_W-1:0] map_length;
    } cfg_t;

    // Controller to datapath
    typedef struct packed {
        logic clr;        // clear one map cell
        logic wr;         // store one map cell from the input word
        logic load;       // capture an update word
        logic red;        // one remainder step on the start cell
        logic scan_init;  // set up the forward scan
        logic scan_run;   // issue and check map cells
        logic fin;        // load the output register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic bad_now;    // input cell at or beyond the ring length
        logic clr_last;   // last cell of the clearing pass
        logic red_last;   // last remainder step
        logic scan_done;  // braking speed settled
        logic out_free;   // output register can take a word
    } sts_t;

endpackage

`default_nettype wire

/* design/tcvu_regs.sv */
// Configuration register file on an APB-style port.
// Depends on tcvu_pkg for widths, reset values and the register index codes.
`default_nettype none

module tcvu_regs
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tcvu_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [tcvu_pkg::PDATA_W-1:0]  pwdata,
    output logic      [tcvu_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready,
    output tcvu_pkg::cfg_t                     cfg
);

    tcvu_pkg::cfg_t   cfg_reg;
    tcvu_pkg::cfg_t   cfg_next;
    tcvu_pkg::reg_idx_t idx;
    logic             wr_en;

    assign pready = 1'b1;
    assign idx    = tcvu_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel & penable & pwrite & pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                tcvu_pkg::REG_ROAD_LENGTH:
                    cfg_next.road_length = pwdata[tcvu_pkg::LEN_CFG_W-1:0];
                tcvu_pkg::REG_MAX_SPEED:
                    cfg_next.max_speed = pwdata[tcvu_pkg::SPEED_W-1:0];
                tcvu_pkg::REG_SLOW_THRESHOLD:
                    cfg_next.slow_threshold = pwdata[tcvu_pkg::THR_W-1:0];
                tcvu_pkg::REG_MAP_LENGTH:
                    cfg_next.map_length = pwdata[tcvu_pkg::LEN_CFG_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            tcvu_pkg::REG_ROAD_LENGTH:
                prdata = tcvu_pkg::PDATA_W'(cfg_reg.road_length);
            tcvu_pkg::REG_MAX_SPEED:
                prdata = tcvu_pkg::PDATA_W'(cfg_reg.max_speed);
            tcvu_pkg::REG_SLOW_THRESHOLD:
                prdata = tcvu_pkg::PDATA_W'(cfg_reg.slow_threshold);
            tcvu_pkg::REG_MAP_LENGTH:
                prdata = tcvu_pkg::PDATA_W'(cfg_reg.map_length);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.road_length    <= tcvu_pkg::ROAD_LENGTH_RST;
            cfg_reg.max_speed      <= tcvu_pkg::MAX_SPEED_RST;
            cfg_reg.slow_threshold <= tcvu_pkg::SLOW_THRESHOLD_RST;
            cfg_reg.map_length     <= tcvu_pkg::MAP_LENGTH_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

/* design/tcvu_ctrl.sv */
// Controller state machine: clearing pass, item intake, remainder, scan, finish.
// Depends on tcvu_pkg for the command and status structs and the function codes.
`default_nettype none

module tcvu_ctrl
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    input  wire logic         func,
    output logic              in_stall,
    input  tcvu_pkg::sts_t    sts,
    output tcvu_pkg::cmd_t    cmd
);

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_REDUCE = 6'b000100,
        S_PREP   = 6'b001000,
        S_SCAN   = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (sts.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (func == tcvu_pkg::FUNC_UPDATE)
                    begin
                        cmd.load   = 1'b1;
                        state_next = sts.bad_now ? S_REDUCE : S_PREP;
                    end
                    else
                    begin
                        cmd.wr = 1'b1;
                    end
                end
            end
            S_REDUCE:
            begin
                cmd.red = 1'b1;
                if (sts.red_last)
                    state_next = S_PREP;
            end
            S_PREP:
            begin
                cmd.scan_init = 1'b1;
                state_next    = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (sts.scan_done)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.fin    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

/* design/tcvu_dp.sv */
// Datapath: occupancy map memory, start-cell remainder unit, pipelined forward
// scan and output register. Depends on tcvu_pkg; driven by tcvu_ctrl commands.
`default_nettype none

module tcvu_dp
#(
    parameter int ROAD_CELLS = tcvu_pkg::ROAD_CELLS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  tcvu_pkg::cfg_t            cfg,
    input  tcvu_pkg::cmd_t            cmd,
    output tcvu_pkg::sts_t            sts,
    input  wire tcvu_pkg::cell_t      cell_req,
    input  wire logic                 occupied,
    input  wire tcvu_pkg::speed_t     speed_in,
    input  wire logic [tcvu_pkg::DRAW_W-1:0] random_draw,
    input  wire logic                 out_stall,
    output logic                      out_valid,
    output tcvu_pkg::cell_t           new_cell,
    output tcvu_pkg::speed_t          new_speed,
    output logic                      bad_position
);

    localparam int AW    = $clog2(ROAD_CELLS);
    localparam int CW    = (AW + 1 > tcvu_pkg::LEN_CFG_W) ? AW + 1 : tcvu_pkg::LEN_CFG_W;
    localparam int SW    = tcvu_pkg::SPEED_W;
    localparam int CELLW = tcvu_pkg::CELL_W;
    localparam int RCW   = $clog2(CELLW);

    typedef logic [AW-1:0]  pos_t;
    typedef logic [CW-1:0]  cmp_t;
    typedef logic [RCW-1:0] rcnt_t;
    typedef logic [SW:0]    jcnt_t;

    // map memory
    logic occ_mem [ROAD_CELLS];
    logic mem_we;
    pos_t mem_waddr;
    logic mem_wdata;
    logic rd_reg;

    // control registers
    pos_t clr_addr_reg;
    logic done_reg;
    logic chk_valid_reg;
    logic out_valid_reg;
    rcnt_t red_cnt_reg;

    // work registers
    tcvu_pkg::speed_t vacc_reg;
    logic             slow_reg;
    logic             bad_reg;
    tcvu_pkg::cell_t  cell_sh_reg;
    pos_t             base_reg;
    pos_t             iss_ptr_reg;
    jcnt_t            iss_j_reg;
    pos_t             chk_ptr_reg;
    tcvu_pkg::speed_t chk_j_reg;
    logic             chk_inmap_reg;
    pos_t             last_ok_reg;
    pos_t             prev_ok_reg;
    tcvu_pkg::speed_t vb_reg;
    tcvu_pkg::cell_t  new_cell_reg;
    tcvu_pkg::speed_t new_speed_reg;
    logic             bad_out_reg;

    // combinational
    cmp_t  road_ext;
    cmp_t  eff_len;
    cmp_t  cell_ext;
    logic  wr_ok;
    cmp_t  red_sh;
    pos_t  red_rem;
    logic [SW:0] speed_p1;
    tcvu_pkg::speed_t vacc_now;
    logic  slow_now;
    logic  iss_act;
    logic  busy;
    pos_t  iss_ptr_nx;
    pos_t  base_nx;
    logic  slowdown;

    function automatic pos_t next_pos(input pos_t p, input cmp_t len);
        cmp_t s;
        s = cmp_t'(p) + cmp_t'(1);
        return (s == len) ? '0 : pos_t'(s);
    endfunction

    // clamp the ring length into the range the map supports
    always_comb
    begin
        road_ext = cmp_t'(cfg.road_length);
        if (road_ext < cmp_t'(tcvu_pkg::MIN_ROAD))
            eff_len = cmp_t'(tcvu_pkg::MIN_ROAD);
        else if (road_ext > cmp_t'(ROAD_CELLS))
            eff_len = cmp_t'(ROAD_CELLS);
        else
            eff_len = road_ext;
    end

    assign cell_ext = cmp_t'(cell_req);
    assign wr_ok    = cell_ext < cmp_t'(ROAD_CELLS);

    // accelerate and braking draw, taken at load
    assign speed_p1 = {1'b0, speed_in} + (SW + 1)'(1);
    assign vacc_now = (speed_p1 > {1'b0, cfg.max_speed}) ? cfg.max_speed : speed_p1[SW-1:0];
    assign slow_now = {1'b0, random_draw} < cfg.slow_threshold;

    // restoring remainder, one start-cell bit per step
    always_comb
    begin
        red_sh = (cmp_t'(base_reg) << 1) | cmp_t'(cell_sh_reg[CELLW-1]);
        if (red_sh >= eff_len)
            red_rem = pos_t'(red_sh - eff_len);
        else
            red_rem = pos_t'(red_sh);
    end

    assign base_nx    = next_pos(base_reg, eff_len);
    assign iss_ptr_nx = next_pos(iss_ptr_reg, eff_len);
    assign iss_act    = cmd.scan_run & ~done_reg & (iss_j_reg <= {1'b0, vacc_reg});
    assign busy       = chk_valid_reg & chk_inmap_reg & rd_reg;
    assign slowdown   = slow_reg & (vb_reg != '0);

    // memory ports
    assign mem_we    = cmd.clr | (cmd.wr & wr_ok);
    assign mem_waddr = cmd.clr ? clr_addr_reg : pos_t'(cell_ext);
    assign mem_wdata = cmd.clr ? 1'b0 : occupied;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            occ_mem[mem_waddr] <= mem_wdata;
        rd_reg <= occ_mem[iss_ptr_reg];
    end

    assign sts.bad_now   = cell_ext >= eff_len;
    assign sts.clr_last  = clr_addr_reg == pos_t'(ROAD_CELLS - 1);
    assign sts.red_last  = red_cnt_reg == rcnt_t'(CELLW - 1);
    assign sts.scan_done = done_reg;
    assign sts.out_free  = ~out_valid_reg | ~out_stall;

    assign out_valid    = out_valid_reg;
    assign new_cell     = new_cell_reg;
    assign new_speed    = new_speed_reg;
    assign bad_position = bad_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg  <= '0;
            done_reg      <= 1'b0;
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            red_cnt_reg   <= '0;
        end
        else
        begin
            if (cmd.clr)
                clr_addr_reg <= clr_addr_reg + pos_t'(1);

            if (cmd.load)
                red_cnt_reg <= '0;
            else if (cmd.red)
                red_cnt_reg <= red_cnt_reg + rcnt_t'(1);

            if (cmd.scan_init)
            begin
                chk_valid_reg <= 1'b0;
                done_reg      <= (vacc_reg == '0);
            end
            else if (cmd.scan_run & ~done_reg)
            begin
                chk_valid_reg <= iss_act & ~busy;
                if (busy || (chk_valid_reg && chk_j_reg == vacc_reg))
                    done_reg <= 1'b1;
            end

            if (cmd.fin)
                out_valid_reg <= 1'b1;
            else if (~out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            vacc_reg    <= vacc_now;
            slow_reg    <= slow_now;
            bad_reg     <= sts.bad_now;
            cell_sh_reg <= cell_req;
            base_reg    <= sts.bad_now ? '0 : pos_t'(cell_ext);
        end
        else if (cmd.red)
        begin
            cell_sh_reg <= cell_sh_reg << 1;
            base_reg    <= red_rem;
        end

        if (cmd.scan_init)
        begin
            iss_ptr_reg <= base_nx;
            iss_j_reg   <= jcnt_t'(1);
            last_ok_reg <= base_reg;
            prev_ok_reg <= base_reg;
            vb_reg      <= '0;
        end
        else if (cmd.scan_run & ~done_reg)
        begin
            chk_ptr_reg   <= iss_ptr_reg;
            chk_j_reg     <= iss_j_reg[SW-1:0];
            chk_inmap_reg <= cmp_t'(iss_ptr_reg) < cmp_t'(cfg.map_length);
            if (iss_act)
            begin
                iss_ptr_reg <= iss_ptr_nx;
                iss_j_reg   <= iss_j_reg + jcnt_t'(1);
            end
            // first occupied cell cuts the speed; each clear cell extends the run
            if (busy)
            begin
                vb_reg <= chk_j_reg - tcvu_pkg::speed_t'(1);
            end
            else if (chk_valid_reg)
            begin
                last_ok_reg <= chk_ptr_reg;
                prev_ok_reg <= last_ok_reg;
                if (chk_j_reg == vacc_reg)
                    vb_reg <= vacc_reg;
            end
        end

        if (cmd.fin)
        begin
            new_cell_reg  <= tcvu_pkg::cell_t'(slowdown ? prev_ok_reg : last_ok_reg);
            new_speed_reg <= slowdown ? vb_reg - tcvu_pkg::speed_t'(1) : vb_reg;
            bad_out_reg   <= bad_reg;
        end
    end

endmodule

`default_nettype wire

/* design/traffic_cell_vehicle_update.sv */
// Top level of the ring-road traffic cell vehicle update block.
// Instantiates tcvu_regs, tcvu_ctrl and tcvu_dp; depends on tcvu_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one word per item. With func
//   at map-write the word stores the occupied bit of cell cell_req in the
//   occupancy map and gives no result. With func at
//   update the word moves one vehicle and gives exactly one result word on
//   the output channel (out_valid / out_stall): new_cell, new_speed and
//   bad_position.
//   An update scans at most vacc cells ahead of its start cell,
//   where vacc is min(speed_in + 1, max_speed): the forward scan reads one
//   map cell per cycle through the single read port of the map memory, with
//   the read and the occupancy check overlapped. An occupied cell at distance
//   j stops the scan early; a vacc of 0 reads no map cells. A start
//   cell at or beyond the ring length first passes through the bit-serial
//   remainder unit.
//   After reset the map is swept clear, one cell per cycle, all ROAD_CELLS
//   cells, with in_stall high; registers are writable during the sweep.
//   The result sits in an output register: while the receiver stalls it
//   holds, and new words are still accepted until a second result is ready.
//   Configuration registers sit on the APB-style port at 4-byte spacing.
`default_nettype none

module traffic_cell_vehicle_update
#(
    parameter int ROAD_CELLS = tcvu_pkg::ROAD_CELLS_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // item channel
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          func,
    input  wire logic [tcvu_pkg::CELL_W-1:0]   cell_req,
    input  wire logic                          occupied,
    input  wire logic [tcvu_pkg::SPEED_W-1:0]  speed_in,
    input  wire logic [tcvu_pkg::DRAW_W-1:0]   random_draw,
    // result channel
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [tcvu_pkg::CELL_W-1:0]   new_cell,
    output logic      [tcvu_pkg::SPEED_W-1:0]  new_speed,
    output logic                               bad_position,
    // configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tcvu_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [tcvu_pkg::PDATA_W-1:0]  pwdata,
    output logic      [tcvu_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready
);

    tcvu_pkg::cfg_t cfg;
    tcvu_pkg::cmd_t dp_cmd;
    tcvu_pkg::sts_t dp_sts;

    // register file
    tcvu_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencing: clear, intake, remainder, scan, finish
    tcvu_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .func     (func),
        .in_stall (in_stall),
        .sts      (dp_sts),
        .cmd      (dp_cmd)
    );

    // map memory, scan pipeline and output register
    tcvu_dp #(
        .ROAD_CELLS (ROAD_CELLS)
    ) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cmd          (dp_cmd),
        .sts          (dp_sts),
        .cell_req     (cell_req),
        .occupied     (occupied),
        .speed_in     (speed_in),
        .random_draw  (random_draw),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .new_cell     (new_cell),
        .new_speed    (new_speed),
        .bad_position (bad_position)
    );

    // a result never overwrites one the receiver has not taken
    a_fin_free: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.fin |-> (!out_valid || !out_stall))
        else $error("result loaded over a held word");

    // no item enters while the forward scan is running
    a_scan_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.scan_run |-> in_stall)
        else $error("item accepted during scan");

    // speed out never exceeds the configured limit
    a_speed_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (new_speed <= cfg.max_speed))
        else $error("new_speed above max_speed");

endmodule

`default_nettype wire

/* sim/traffic_cell_vehicle_update_test.sv */
`timescale 1ns / 100ps
// Self-checking bench for the ring-road traffic cell vehicle update block.
// Drives map and vehicle words, predicts each move and checks the results.
// Depends on tcvu_pkg and traffic_cell_vehicle_update only.

module traffic_cell_vehicle_update_test;

    import tcvu_pkg::*;

    localparam int          ROAD_CELLS   = ROAD_CELLS_DEF;
    // Drain wait after each phase, with a wide margin over the longest update.
    localparam int          DRAIN_CYCLES = 64;
    // Watchdog limit; the slowest legal run is roughly 1100 words.
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int          PHASE_WORDS  = 108;

    typedef struct {
        logic              func;
        cell_t             cell_no;
        logic              occ;
        speed_t            speed;
        logic [DRAW_W-1:0] draw;
    } traffic_word_t;

    typedef struct {
        cell_t  cell_no;
        speed_t speed;
        logic   bad;
    } vehicle_move_t;

    logic clk;
    logic rst_n = 1'b0;

    logic                in_valid    = 1'b0;
    logic                in_stall;
    logic                func        = FUNC_MAP_WRITE;
    cell_t               cell_req    = '0;
    logic                occupied    = 1'b0;
    speed_t              speed_in    = '0;
    logic [DRAW_W-1:0]   random_draw = '0;

    logic                out_valid;
    logic                out_stall   = 1'b0;
    cell_t               new_cell;
    speed_t              new_speed;
    logic                bad_position;

    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [PADDR_W-1:0]  paddr       = '0;
    logic [PDATA_W-1:0]  pwdata      = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    // Predictor state: register copy and occupancy map copy.
    cfg_t                cfg_shadow;
    bit                  occ_shadow [ROAD_CELLS];

    traffic_word_t       word_backlog [$];
    vehicle_move_t       moves_due [$];
    traffic_word_t       live_word;

    int unsigned         words_queued  = 0;
    int unsigned         words_taken   = 0;
    int unsigned         moves_checked = 0;
    int unsigned         map_writes    = 0;
    int unsigned         bad_starts    = 0;
    int unsigned         gap_brakes    = 0;
    int unsigned         slowdowns     = 0;
    int unsigned         settings_done = 0;
    int unsigned         fault_count   = 0;
    int unsigned         cycle_count   = 0;
    int unsigned         send_gap      = 0;
    int unsigned         hold_left     = 0;
    bit                  quiet_send    = 1'b0;
    bit                  quiet_recv    = 1'b0;

    traffic_cell_vehicle_update dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .cell_req     (cell_req),
        .occupied     (occupied),
        .speed_in     (speed_in),
        .random_draw  (random_draw),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .new_cell     (new_cell),
        .new_speed    (new_speed),
        .bad_position (bad_position),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Ring length as the block sees it: clamp into [MIN_ROAD, ROAD_CELLS].
    function automatic int unsigned ring_cells();
        int unsigned n;
        n = cfg_shadow.road_length;
        if (n < MIN_ROAD) n = MIN_ROAD;
        if (n > ROAD_CELLS) n = ROAD_CELLS;
        return n;
    endfunction

    // Idle or stall length for one word; quiet stretches run back to back.
    function automatic int unsigned pause_len(input bit quiet);
        if (quiet || $urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 19);
    endfunction

    // Apply one accepted word to the predictor: store a map bit, or run the
    // four traffic rules and queue the move the block must report.
    task automatic nasch_step(input traffic_word_t w);
        int unsigned   len;
        int unsigned   v;
        int unsigned   j;
        int unsigned   spot;
        vehicle_move_t m;
        if (w.func == FUNC_MAP_WRITE)
        begin
            occ_shadow[w.cell_no] = w.occ;
            map_writes++;
            return;
        end
        len = ring_cells();
        // accelerate, capped by the speed limit (a limit of 0 pins speed at 0)
        v = w.speed + 1;
        if (v > cfg_shadow.max_speed) v = cfg_shadow.max_speed;
        // look ahead with wrap; cells outside the mapped span read as empty
        for (j = 1; j <= v; j++)
        begin
            spot = (w.cell_no + j) % len;
            if (spot < cfg_shadow.map_length && spot < ROAD_CELLS && occ_shadow[spot])
            begin
                v = j - 1;
                gap_brakes++;
                break;
            end
        end
        // random slowdown, never below standstill
        if (w.draw < cfg_shadow.slow_threshold && v > 0)
        begin
            v--;
            slowdowns++;
        end
        m.cell_no = cell_t'((w.cell_no + v) % len);
        m.speed   = speed_t'(v);
        m.bad     = (w.cell_no >= len);
        if (m.bad) bad_starts++;
        moves_due.push_back(m);
    endtask

    task automatic push_word(input logic f, input int unsigned c, input logic o,
                             input int unsigned s, input int unsigned d);
        traffic_word_t w;
        w.func    = f;
        w.cell_no = cell_t'(c);
        w.occ     = o;
        w.speed   = speed_t'(s);
        w.draw    = DRAW_W'(d);
        word_backlog.push_back(w);
        words_queued++;
    endtask

    // Random traffic for the current setting: most cells land in a small
    // window so the map gets dense enough to force braking, some anywhere on
    // the ring, and a few anywhere in the cell range (bad start cells).
    task automatic queue_traffic(input int unsigned count);
        int unsigned span;
        int unsigned win;
        int unsigned base;
        int unsigned pick;
        int unsigned k;
        int unsigned c;
        int unsigned d;
        span = ring_cells();
        win  = (span < 64) ? span : 64;
        base = $urandom_range(0, span - win);
        for (k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)      c = base + $urandom_range(0, win - 1);
            else if (pick < 85) c = $urandom_range(0, span - 1);
            else                c = $urandom_range(0, ROAD_CELLS - 1);
            // hug the braking threshold now and then
            if ($urandom_range(0, 3) == 0)
                d = cfg_shadow.slow_threshold + $urandom_range(0, 4) - 2;
            else
                d = $urandom();
            push_word(($urandom_range(0, 99) < 35) ? FUNC_MAP_WRITE : FUNC_UPDATE,
                      c, $urandom_range(0, 1), $urandom(), d);
        end
    endtask

    // Write one register (setup, access), then read it back.
    task automatic reg_write(input reg_idx_t idx, input logic [PDATA_W-1:0] val);
        logic [PDATA_W-1:0] seen;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_ROAD_LENGTH:    cfg_shadow.road_length    = val[LEN_CFG_W-1:0];
            REG_MAX_SPEED:      cfg_shadow.max_speed      = val[SPEED_W-1:0];
            REG_SLOW_THRESHOLD: cfg_shadow.slow_threshold = val[THR_W-1:0];
            REG_MAP_LENGTH:     cfg_shadow.map_length     = val[LEN_CFG_W-1:0];
            default: ;
        endcase
        // hold psel: this cycle is the setup of the read
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        seen = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (seen !== val)
        begin
            fault_count++;
            $display("%0t: register %s read back %0d, expected %0d",
                     $time, idx.name(), seen, val);
        end
    endtask

    task automatic load_setting(input int unsigned road, input int unsigned vmax,
                                input int unsigned thr, input int unsigned span);
        reg_write(REG_ROAD_LENGTH, road);
        reg_write(REG_MAX_SPEED, vmax);
        reg_write(REG_SLOW_THRESHOLD, thr);
        reg_write(REG_MAP_LENGTH, span);
        settings_done++;
    endtask

    // Block until every queued word is taken and every move reported, then
    // let the pipeline drain so a trailing map write has landed.
    task automatic wait_quiet();
        while (words_taken != words_queued || moves_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Sequencer: reset, directed words at reset settings, then random phases.
    initial
    begin
        int unsigned k;
        cfg_shadow.road_length    = ROAD_LENGTH_RST;
        cfg_shadow.max_speed      = MAX_SPEED_RST;
        cfg_shadow.slow_threshold = SLOW_THRESHOLD_RST;
        cfg_shadow.map_length     = MAP_LENGTH_RST;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words; ring of 300, limit 5, map covers 300 cells.
        push_word(FUNC_MAP_WRITE, 5, 1'b1, $urandom(), $urandom());
        push_word(FUNC_MAP_WRITE, 0, 1'b1, $urandom(), $urandom());
        push_word(FUNC_MAP_WRITE, 299, 1'b1, $urandom(), $urandom());
        push_word(FUNC_MAP_WRITE, 1023, 1'b1, $urandom(), $urandom());  // outside map span
        push_word(FUNC_UPDATE, 3, 1'b0, 4, 16'hFFFF);      // brake behind cell 5
        push_word(FUNC_UPDATE, 298, 1'b0, 31, 16'hFFFF);   // speed capped, blocked at once
        push_word(FUNC_UPDATE, 299, 1'b0, 2, 0);           // wrap blocked by cell 0
        push_word(FUNC_UPDATE, 100, 1'b0, 0, 0);           // slowdown from 1 to 0
        push_word(FUNC_UPDATE, 100, 1'b0, 10, 13106);      // draw just under threshold
        push_word(FUNC_UPDATE, 100, 1'b0, 10, 13107);      // draw at threshold
        push_word(FUNC_UPDATE, 300, 1'b0, 3, 16'hFFFF);    // start cell at ring length
        push_word(FUNC_UPDATE, 1023, 1'b1, 31, 16'hFFFF);  // top cell, far off the ring
        push_word(FUNC_MAP_WRITE, 5, 1'b0, $urandom(), $urandom());
        push_word(FUNC_UPDATE, 1, 1'b0, 31, 40000);        // cleared cell lets it through
        push_word(FUNC_UPDATE, 295, 1'b0, 4, 16'hFFFF);    // blocked by cell 299 short of the wrap
        push_word(FUNC_UPDATE, 0, 1'b0, 31, 16'hFFFF);     // own cell occupied, not scanned
        push_word(FUNC_UPDATE, 299, 1'b0, 31, 13106);      // own cell occupied, wrap blocked
        push_word(FUNC_UPDATE, 250, 1'b0, 0, 16'hFFFF);
        wait_quiet();

        // Fixed settings: extremes and out-of-range clamps.
        load_setting(1024, 31, 0, 1024);
        queue_traffic(PHASE_WORDS);
        wait_quiet();
        load_setting(2, 31, 65536, 2);          // tiny ring, brake on every draw
        queue_traffic(PHASE_WORDS);
        wait_quiet();
        load_setting(0, 0, 131071, 0);          // ring clamps to 2, speed pinned
        queue_traffic(PHASE_WORDS);
        wait_quiet();
        load_setting(2047, 31, 32768, 2047);    // ring clamps to full depth
        queue_traffic(PHASE_WORDS);
        wait_quiet();
        load_setting(1, 7, 1, 1023);
        queue_traffic(PHASE_WORDS);
        wait_quiet();
        load_setting(40, 12, 16384, 20);        // map shorter than the ring
        queue_traffic(PHASE_WORDS);
        wait_quiet();

        // Random settings, mostly short rings so scans wrap and hit.
        for (k = 0; k < 4; k++)
        begin
            load_setting(($urandom_range(0, 2) == 0) ? $urandom_range(0, 2047)
                                                     : $urandom_range(2, 120),
                         $urandom_range(0, 31),
                         ($urandom_range(0, 1) == 0) ? $urandom_range(0, 131071)
                                                     : $urandom_range(0, 30000),
                         $urandom_range(0, 2047));
            queue_traffic(PHASE_WORDS);
            wait_quiet();
        end

        $display("run: %0d words over %0d register settings, %0d moves checked, %0d map writes",
                 words_taken, settings_done, moves_checked, map_writes);
        $display("run: %0d bad start cells, %0d look-ahead brakes, %0d random slowdowns",
                 bad_starts, gap_brakes, slowdowns);
        if (fault_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Word driver: hold the word until taken, then idle a random gap.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                nasch_step(live_word);
                words_taken++;
                if (words_taken % 40 == 0) quiet_send = ($urandom_range(0, 4) == 0);
            end
            if (!in_valid || !in_stall)
            begin
                if (send_gap != 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (word_backlog.size() != 0)
                begin
                    live_word = word_backlog.pop_front();
                    in_valid    <= 1'b1;
                    func        <= live_word.func;
                    cell_req    <= live_word.cell_no;
                    occupied    <= live_word.occ;
                    speed_in    <= live_word.speed;
                    random_draw <= live_word.draw;
                    send_gap = pause_len(quiet_send);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: check each taken word against the oldest predicted
    // move, then stall a random number of cycles.
    always @(posedge clk)
    begin
        vehicle_move_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (moves_due.size() == 0)
                begin
                    fault_count++;
                    $display("%0t: unexpected result cell %0d speed %0d bad %0b",
                             $time, new_cell, new_speed, bad_position);
                end
                else
                begin
                    want = moves_due.pop_front();
                    moves_checked++;
                    if (new_cell !== want.cell_no || new_speed !== want.speed ||
                        bad_position !== want.bad)
                    begin
                        fault_count++;
                        $display({"%0t: mismatch expected cell %0d speed %0d bad %0b, ",
                                  "got cell %0d speed %0d bad %0b"},
                                 $time, want.cell_no, want.speed, want.bad,
                                 new_cell, new_speed, bad_position);
                    end
                end
                if (moves_checked % 40 == 0) quiet_recv = ($urandom_range(0, 4) == 0);
                hold_left = pause_len(quiet_recv);
            end
            if (hold_left != 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: abort a run that stops making progress.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

endmodule
